// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the number-to-ASCII formatter.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define NTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define NTA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/nta_pkg.sv
// Package of the number-to-ASCII formatter: format codes, pipeline item type,
// character and double-dabble helpers. Depends on nothing.
`default_nettype none

package nta_pkg;

    localparam logic [2:0] FMT_HEX8  = 3'd0;
    localparam logic [2:0] FMT_HEX16 = 3'd1;
    localparam logic [2:0] FMT_HEX32 = 3'd2;
    localparam logic [2:0] FMT_BIN8  = 3'd3;
    localparam logic [2:0] FMT_DEC16 = 3'd4;
    localparam logic [2:0] FMT_DEC32 = 3'd5;

    localparam int NUM_POS  = 10;           // character slots in one text
    localparam int DIG_W    = 4;
    localparam int BCD_W    = NUM_POS * DIG_W;
    localparam int VAL_W    = 32;
    localparam int BITS_PER_STAGE = 8;      // double-dabble steps per stage
    localparam int NUM_STAGES = VAL_W / BITS_PER_STAGE;

    localparam logic [3:0] POS_HEX8  = 4'd8;
    localparam logic [3:0] POS_HEX16 = 4'd6;
    localparam logic [3:0] POS_WIDE8 = 4'd2;
    localparam logic [3:0] LAST_POS  = 4'd9;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_ONE    = 8'h31;
    localparam logic [7:0] ASCII_LETTER = 8'h37;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic [2:0]       func;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_item;

    function automatic t_char hex_char(input logic [3:0] nib);
        if (nib > 4'd9) begin
            return ASCII_LETTER + {4'd0, nib};
        end
        return ASCII_ZERO + {4'd0, nib};
    endfunction

    // Run one stage worth of shift-and-add-3 steps.
    function automatic t_item dabble_steps(input t_item it);
        t_item r;
        r = it;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_POS; d++) begin
                if (r.bcd[d*DIG_W +: DIG_W] >= 4'd5) begin
                    r.bcd[d*DIG_W +: DIG_W] = r.bcd[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.bin[VAL_W-1]};
            r.bin = {r.bin[VAL_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/nta_dabble_stage.sv
// One register stage of the binary-to-BCD pipeline with its valid bit.
// Depends on nta_pkg.
`default_nettype none

module nta_dabble_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire nta_pkg::t_item i_data,
    input  wire logic          i_ready_next,
    output logic               o_ready,
    output logic               o_valid,
    output nta_pkg::t_item     o_data
);
    import nta_pkg::*;

    logic  r_v;
    t_item r_data;

    // Take a new item when empty or when the held one moves on.
    assign o_ready = !r_v || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= dabble_steps(i_data);
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: src/number_to_ascii_formatter_top.sv
// Top level of the number-to-ASCII formatter: BCD pipeline, format stage and
// character serializer. Depends on nta_pkg, nta_dabble_stage, assert_macros.svh.
//
// A transfer on the input side happens at a clock edge with i_start high and
// o_busy low; it carries a format code (hex8, hex16, hex32, bin8, dec16,
// dec32) and a 32-bit number. The text comes out one character per cycle on
// o_ascii_char, marked by o_strobe, most significant character first, with
// o_last on the final one; the characters of one number are always on
// consecutive cycles and the receiver must take every one, it cannot stall.
// Hex prints 2, 4 or 8 upper-case digits, bin8 prints 8 characters, decimal
// prints 1 to 10 digits without leading zeros. Codes 6 and 7 give no text.
// A number passes four double-dabble stages of 8 steps each, one format
// stage and the serializer before its first character leaves.
// The pipeline takes an item in every cycle while it has room; sustained
// throughput is set by the single serializer, which sends one character a
// cycle, 1 to 10 per item, and loads the next text as it sends the last. When
// the pipeline has filled behind a long text, o_busy rises.
`default_nettype none

`include "assert_macros.svh"

module number_to_ascii_formatter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_value,
    output logic             o_strobe,
    output logic [7:0]       o_ascii_char,
    output logic             o_last
);
    import nta_pkg::*;

    // ---------------------------------------------------------------
    // BCD pipeline: stage k reads d_pipe[k], writes d_pipe[k+1].
    // ---------------------------------------------------------------
    t_item d_pipe   [0:NUM_STAGES];
    logic  v_pipe   [0:NUM_STAGES];
    logic  rdy_pipe [0:NUM_STAGES];
    logic  fmt_ready;

    // dec16 reads only the low half; everything else converts the full word.
    always_comb begin
        d_pipe[0].func  = i_func;
        d_pipe[0].value = i_value;
        d_pipe[0].bin   = (i_func == FMT_DEC16) ? {16'd0, i_value[15:0]} : i_value;
        d_pipe[0].bcd   = '0;
    end
    assign v_pipe[0]           = i_start;
    assign rdy_pipe[NUM_STAGES] = fmt_ready;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        nta_dabble_stage u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (v_pipe[k]),
            .i_data       (d_pipe[k]),
            .i_ready_next (rdy_pipe[k+1]),
            .o_ready      (rdy_pipe[k]),
            .o_valid      (v_pipe[k+1]),
            .o_data       (d_pipe[k+1])
        );
    end

    // Hold off the sender only when the first stage is full and stuck.
    assign o_busy = !rdy_pipe[0];

    // ---------------------------------------------------------------
    // Format stage: text right-aligned in ten slots; a start position
    // marks the first character, the last slot is always the end.
    // ---------------------------------------------------------------
    logic       r_fv;
    t_char      r_fchars [0:NUM_POS-1];
    logic [3:0] r_fstart;
    logic       n_fv;
    t_char      n_fchars [0:NUM_POS-1];
    logic [3:0] n_fstart;
    t_item      f_in;
    logic       ser_ready;

    assign f_in      = d_pipe[NUM_STAGES];
    assign fmt_ready = !r_fv || ser_ready;

    always_comb begin
        // Drop unused format codes here: they make no text.
        n_fv     = v_pipe[NUM_STAGES] && (f_in.func inside {[FMT_HEX8:FMT_DEC32]});
        n_fstart = LAST_POS;
        for (int p = 0; p < NUM_POS; p++) begin
            n_fchars[p] = ASCII_ZERO;
        end
        case (f_in.func)
            FMT_HEX8, FMT_HEX16, FMT_HEX32: begin
                for (int p = 2; p < NUM_POS; p++) begin
                    n_fchars[p] = hex_char(f_in.value[(NUM_POS-1-p)*DIG_W +: DIG_W]);
                end
                if (f_in.func == FMT_HEX8) begin
                    n_fstart = POS_HEX8;
                end else if (f_in.func == FMT_HEX16) begin
                    n_fstart = POS_HEX16;
                end else begin
                    n_fstart = POS_WIDE8;
                end
            end
            FMT_BIN8: begin
                for (int p = 2; p < NUM_POS; p++) begin
                    n_fchars[p] = f_in.value[NUM_POS-1-p] ? ASCII_ONE : ASCII_ZERO;
                end
                n_fstart = POS_WIDE8;
            end
            FMT_DEC16, FMT_DEC32: begin
                for (int p = 0; p < NUM_POS; p++) begin
                    n_fchars[p] = ASCII_ZERO
                                + {4'd0, f_in.bcd[(NUM_POS-1-p)*DIG_W +: DIG_W]};
                end
                // First nonzero digit; zero itself keeps the lone last digit.
                for (int p = NUM_POS - 2; p >= 0; p--) begin
                    if (f_in.bcd[(NUM_POS-1-p)*DIG_W +: DIG_W] != 4'd0) begin
                        n_fstart = 4'(p);
                    end
                end
            end
            default: begin
                n_fstart = LAST_POS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (fmt_ready) begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fmt_ready) begin
            r_fchars <= n_fchars;
            r_fstart <= n_fstart;
        end
    end

    // ---------------------------------------------------------------
    // Serializer: one character per cycle, the next text loads on the
    // cycle that sends the last character of the current one.
    // ---------------------------------------------------------------
    logic       r_sv;
    t_char      r_schars [0:NUM_POS-1];
    logic [3:0] r_sidx;

    assign ser_ready = !r_sv || (r_sidx == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_sidx <= LAST_POS;
        end else if (ser_ready) begin
            r_sv   <= r_fv;
            r_sidx <= r_fstart;
        end else begin
            r_sidx <= r_sidx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_ready) begin
            r_schars <= r_fchars;
        end
    end

    assign o_strobe     = r_sv;
    assign o_ascii_char = r_schars[r_sidx];
    assign o_last       = (r_sidx == LAST_POS);

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `NTA_ASSERT(a_text_contiguous, o_strobe && !o_last |=> o_strobe, "gap inside one text")
    `NTA_ASSERT(a_busy_means_full, o_busy |-> v_pipe[1], "busy with an empty first stage")
    `NTA_ASSERT(a_idx_in_range, r_sidx <= LAST_POS, "serializer index past the end")

endmodule

`default_nettype wire
